FILE: rtl/smt_pkg.sv
package smt_pkg;

  // field widths
  localparam int PIX_W     = 16;
  localparam int FOC_W     = 16;
  localparam int BASE_W    = 20;
  localparam int DEPTH_W   = 24;
  localparam int DIST_W    = 9;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // internal widths
  localparam int OFF_W  = PIX_W + 1;          // signed pixel offset
  localparam int NUM_W  = BASE_W + FOC_W;     // baseline * focal_x
  localparam int PROD_W = PIX_W + DEPTH_W;    // |offset| * depth
  localparam int QUO_W  = DEPTH_W;            // quotient bits kept by the dividers

  // saturation limits, Q8.16
  localparam logic [DEPTH_W-1:0] POS_SAT = 24'h7F_FFFF;
  localparam logic [DEPTH_W-1:0] NEG_SAT = 24'h80_0000;
  localparam logic [DEPTH_W-1:0] SAT_LIM = 24'h80_0000;

  // register reset values
  localparam logic [FOC_W-1:0]   RST_FOCAL_X   = 16'd8000;
  localparam logic [FOC_W-1:0]   RST_FOCAL_Y   = 16'd8000;
  localparam logic [PIX_W-1:0]   RST_CENTER_X  = 16'd5120;
  localparam logic [PIX_W-1:0]   RST_CENTER_Y  = 16'd3840;
  localparam logic [BASE_W-1:0]  RST_BASELINE  = 20'd32768;
  localparam logic [DIST_W-1:0]  RST_THRESHOLD = 9'd50;
  localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH = 24'd2293760;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_BASELINE  = 3'd4,
    REG_THRESHOLD = 3'd5,
    REG_MAX_DEPTH = 3'd6
  } cfg_reg_t;

  // first stage result, ahead of the depth divider
  typedef struct packed {
    logic                    keep;
    logic [NUM_W-1:0]        num;
    logic [PIX_W-1:0]        disp;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
  } front_t;

endpackage

FILE: rtl/stereo_match_triangulator_unit.sv
// Stereo match triangulator: turns one left/right feature match per transfer into a 3-D point
// (Q8.16 metres) by the pinhole model, z = baseline*focal_x/disparity, x and y from the
// pixel offsets to the principal point. Matches whose distance reaches match_threshold,
// with non-positive disparity, or whose depth is zero or at/above max_depth give no
// result; x and y saturate. Throughput is one transfer per clock while the result side does
// not stall. Each transfer passes the front register, the 25-stage bit-per-cycle
// depth divider (an entry stage plus 24 quotient bits), the projection multiply register,
// the x and y dividers of the same form in parallel, and the output register.
// A stall on a held result freezes the whole pipeline; a one-entry input skid takes the
// transfer in flight, so in_stall is a registered signal. Configuration writes are
// expected only while the pipeline is empty.
module stereo_match_triangulator_unit #(
  parameter int INDEX_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [smt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smt_pkg::CFG_W-1:0]         cfg_wdata,
  // match input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [smt_pkg::DIST_W-1:0]        in_match_distance,
  input  logic [INDEX_BITS-1:0]             in_left_index,
  input  logic [INDEX_BITS-1:0]             in_right_index,
  input  logic [smt_pkg::PIX_W-1:0]         in_left_x,
  input  logic [smt_pkg::PIX_W-1:0]         in_left_y,
  input  logic [smt_pkg::PIX_W-1:0]         in_right_x,
  // point output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smt_pkg::DEPTH_W-1:0]       out_point_x,
  output logic [smt_pkg::DEPTH_W-1:0]       out_point_y,
  output logic [smt_pkg::DEPTH_W-1:0]       out_point_z,
  output logic [INDEX_BITS-1:0]             out_kept_left_index,
  output logic [INDEX_BITS-1:0]             out_kept_right_index,
  output logic [smt_pkg::DIST_W-1:0]        out_score
);

  // pass-through bundle: score and both indices
  localparam int PW  = smt_pkg::DIST_W + 2 * INDEX_BITS;
  // depth divider side: keep flag, both offsets, pass-through
  localparam int ZSW = 1 + 2 * smt_pkg::OFF_W + PW;
  // x divider side: ok flag, y sign is on its own divider, depth, pass-through
  localparam int XSW = 1 + smt_pkg::DEPTH_W + PW;

  // configuration registers
  logic [smt_pkg::FOC_W-1:0]   focal_x_r;
  logic [smt_pkg::FOC_W-1:0]   focal_y_r;
  logic [smt_pkg::PIX_W-1:0]   center_x_r;
  logic [smt_pkg::PIX_W-1:0]   center_y_r;
  logic [smt_pkg::BASE_W-1:0]  baseline_r;
  logic [smt_pkg::DIST_W-1:0]  threshold_r;
  logic [smt_pkg::DEPTH_W-1:0] max_depth_r;

  logic [smt_pkg::FOC_W-1:0]   fx_div;
  logic [smt_pkg::FOC_W-1:0]   fy_div;

  logic                        en;

  // front stage
  logic                        s1_valid;
  smt_pkg::front_t             s1;
  logic [smt_pkg::DIST_W-1:0]  s1_dist;
  logic [INDEX_BITS-1:0]       s1_lidx;
  logic [INDEX_BITS-1:0]       s1_ridx;

  // depth divider
  logic [ZSW-1:0]              zside_i;
  logic [ZSW-1:0]              zside_o;
  logic                        z_v;
  logic [smt_pkg::QUO_W-1:0]   z_q;
  logic                        z_ovf;
  logic                        z_keep;
  logic signed [smt_pkg::OFF_W-1:0] z_off_x;
  logic signed [smt_pkg::OFF_W-1:0] z_off_y;
  logic [PW-1:0]               z_pass;

  // projection stage
  logic                        p_valid;
  logic                        p_ok;
  logic [smt_pkg::DEPTH_W-1:0] p_z;
  logic [smt_pkg::PROD_W-1:0]  mag_x;
  logic                        neg_x;
  logic [smt_pkg::PROD_W-1:0]  mag_y;
  logic                        neg_y;
  logic [PW-1:0]               p_pass;

  // x / y dividers
  logic [XSW-1:0]              xside_i;
  logic [XSW-1:0]              xside_o;
  logic                        x_v;
  logic [smt_pkg::QUO_W-1:0]   x_q;
  logic                        x_ovf;
  logic                        y_v;
  logic [smt_pkg::QUO_W-1:0]   y_q;
  logic                        y_ovf;
  logic                        y_neg;
  logic                        x_neg;
  logic                        x_ok;
  logic [smt_pkg::DEPTH_W-1:0] x_z;
  logic [PW-1:0]               x_pass;
  logic [smt_pkg::DIST_W-1:0]  x_dist;
  logic [INDEX_BITS-1:0]       x_lidx;
  logic [INDEX_BITS-1:0]       x_ridx;

  // register file; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r   <= smt_pkg::RST_FOCAL_X;
      focal_y_r   <= smt_pkg::RST_FOCAL_Y;
      center_x_r  <= smt_pkg::RST_CENTER_X;
      center_y_r  <= smt_pkg::RST_CENTER_Y;
      baseline_r  <= smt_pkg::RST_BASELINE;
      threshold_r <= smt_pkg::RST_THRESHOLD;
      max_depth_r <= smt_pkg::RST_MAX_DEPTH;
    end else if (cfg_we) begin
      unique case (smt_pkg::cfg_reg_t'(cfg_index))
        smt_pkg::REG_FOCAL_X:   focal_x_r   <= cfg_wdata[smt_pkg::FOC_W-1:0];
        smt_pkg::REG_FOCAL_Y:   focal_y_r   <= cfg_wdata[smt_pkg::FOC_W-1:0];
        smt_pkg::REG_CENTER_X:  center_x_r  <= cfg_wdata[smt_pkg::PIX_W-1:0];
        smt_pkg::REG_CENTER_Y:  center_y_r  <= cfg_wdata[smt_pkg::PIX_W-1:0];
        smt_pkg::REG_BASELINE:  baseline_r  <= cfg_wdata[smt_pkg::BASE_W-1:0];
        smt_pkg::REG_THRESHOLD: threshold_r <= cfg_wdata[smt_pkg::DIST_W-1:0];
        smt_pkg::REG_MAX_DEPTH: max_depth_r <= cfg_wdata[smt_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero focal length divides as one (zero focal_x never reaches here: depth is zero)
  assign fx_div = (focal_x_r == '0) ? smt_pkg::FOC_W'(1) : focal_x_r;
  assign fy_div = (focal_y_r == '0) ? smt_pkg::FOC_W'(1) : focal_y_r;

  // skid, threshold and disparity checks, baseline*focal_x, pixel offsets
  smt_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_match_distance (in_match_distance),
    .in_left_index     (in_left_index),
    .in_right_index    (in_right_index),
    .in_left_x         (in_left_x),
    .in_left_y         (in_left_y),
    .in_right_x        (in_right_x),
    .focal_x           (focal_x_r),
    .center_x          (center_x_r),
    .center_y          (center_y_r),
    .baseline          (baseline_r),
    .threshold         (threshold_r),
    .s1_valid          (s1_valid),
    .s1                (s1),
    .s1_dist           (s1_dist),
    .s1_lidx           (s1_lidx),
    .s1_ridx           (s1_ridx)
  );

  assign zside_i = {s1.keep, s1.off_x, s1.off_y, s1_dist, s1_lidx, s1_ridx};

  // depth = baseline*focal_x / disparity, 24 quotient bits plus overflow
  smt_div #(
    .DW (smt_pkg::NUM_W),
    .SW (ZSW)
  ) u_zdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s1_valid),
    .dividend (s1.num),
    .divisor  (s1.disp),
    .side_i   (zside_i),
    .out_v    (z_v),
    .quo      (z_q),
    .ovf      (z_ovf),
    .side_o   (zside_o)
  );

  assign {z_keep, z_off_x, z_off_y, z_pass} = zside_o;

  // depth checks and |offset|*depth
  smt_proj #(
    .PW (PW)
  ) u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (z_v),
    .keep      (z_keep),
    .off_x     (z_off_x),
    .off_y     (z_off_y),
    .z         (z_q),
    .z_ovf     (z_ovf),
    .pass_i    (z_pass),
    .max_depth (max_depth_r),
    .p_valid   (p_valid),
    .p_ok      (p_ok),
    .p_z       (p_z),
    .mag_x     (mag_x),
    .neg_x     (neg_x),
    .mag_y     (mag_y),
    .neg_y     (neg_y),
    .pass_o    (p_pass)
  );

  assign xside_i = {p_ok, p_z, p_pass};

  // x: sign travels one bit wider on the x side bundle
  smt_div #(
    .DW (smt_pkg::PROD_W),
    .SW (XSW + 1)
  ) u_xdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (p_valid),
    .dividend (mag_x),
    .divisor  (fx_div),
    .side_i   ({neg_x, xside_i}),
    .out_v    (x_v),
    .quo      (x_q),
    .ovf      (x_ovf),
    .side_o   ({x_neg, xside_o})
  );

  smt_div #(
    .DW (smt_pkg::PROD_W),
    .SW (1)
  ) u_ydiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (p_valid),
    .dividend (mag_y),
    .divisor  (fy_div),
    .side_i   (neg_y),
    .out_v    (y_v),
    .quo      (y_q),
    .ovf      (y_ovf),
    .side_o   (y_neg)
  );

  assign {x_ok, x_z, x_pass}         = xside_o;
  assign {x_dist, x_lidx, x_ridx}    = x_pass;

  // saturation, sign and the output register; also the pipeline advance
  smt_out #(
    .INDEX_BITS (INDEX_BITS)
  ) u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .en                   (en),
    .x_v                  (x_v),
    .y_v                  (y_v),
    .ok                   (x_ok),
    .qx                   (x_q),
    .ovf_x                (x_ovf),
    .neg_x                (x_neg),
    .qy                   (y_q),
    .ovf_y                (y_ovf),
    .neg_y                (y_neg),
    .z                    (x_z),
    .match_dist           (x_dist),
    .lidx                 (x_lidx),
    .ridx                 (x_ridx),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_point_x          (out_point_x),
    .out_point_y          (out_point_y),
    .out_point_z          (out_point_z),
    .out_kept_left_index  (out_kept_left_index),
    .out_kept_right_index (out_kept_right_index),
    .out_score            (out_score)
  );

endmodule

FILE: rtl/smt_front.sv
module smt_front #(
  parameter int INDEX_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [smt_pkg::DIST_W-1:0]    in_match_distance,
  input  logic [INDEX_BITS-1:0]         in_left_index,
  input  logic [INDEX_BITS-1:0]         in_right_index,
  input  logic [smt_pkg::PIX_W-1:0]     in_left_x,
  input  logic [smt_pkg::PIX_W-1:0]     in_left_y,
  input  logic [smt_pkg::PIX_W-1:0]     in_right_x,
  input  logic [smt_pkg::FOC_W-1:0]     focal_x,
  input  logic [smt_pkg::PIX_W-1:0]     center_x,
  input  logic [smt_pkg::PIX_W-1:0]     center_y,
  input  logic [smt_pkg::BASE_W-1:0]    baseline,
  input  logic [smt_pkg::DIST_W-1:0]    threshold,
  output logic                          s1_valid,
  output smt_pkg::front_t               s1,
  output logic [smt_pkg::DIST_W-1:0]    s1_dist,
  output logic [INDEX_BITS-1:0]         s1_lidx,
  output logic [INDEX_BITS-1:0]         s1_ridx
);

  logic                       skid_v_r;
  logic [smt_pkg::DIST_W-1:0] skid_dist_r;
  logic [INDEX_BITS-1:0]      skid_lidx_r;
  logic [INDEX_BITS-1:0]      skid_ridx_r;
  logic [smt_pkg::PIX_W-1:0]  skid_lx_r;
  logic [smt_pkg::PIX_W-1:0]  skid_ly_r;
  logic [smt_pkg::PIX_W-1:0]  skid_rx_r;

  logic                       in_acc;
  logic                       sel_v;
  logic [smt_pkg::DIST_W-1:0] sel_dist;
  logic [INDEX_BITS-1:0]      sel_lidx;
  logic [INDEX_BITS-1:0]      sel_ridx;
  logic [smt_pkg::PIX_W-1:0]  sel_lx;
  logic [smt_pkg::PIX_W-1:0]  sel_ly;
  logic [smt_pkg::PIX_W-1:0]  sel_rx;
  smt_pkg::front_t            s1_nxt;

  logic                       s1_valid_r;
  smt_pkg::front_t            s1_r;
  logic [smt_pkg::DIST_W-1:0] s1_dist_r;
  logic [INDEX_BITS-1:0]      s1_lidx_r;
  logic [INDEX_BITS-1:0]      s1_ridx_r;

  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !skid_v_r;

  // skid entry has priority; input is stalled while it is full
  always_comb begin
    sel_v    = skid_v_r ? 1'b1 : in_acc;
    sel_dist = skid_v_r ? skid_dist_r : in_match_distance;
    sel_lidx = skid_v_r ? skid_lidx_r : in_left_index;
    sel_ridx = skid_v_r ? skid_ridx_r : in_right_index;
    sel_lx   = skid_v_r ? skid_lx_r   : in_left_x;
    sel_ly   = skid_v_r ? skid_ly_r   : in_left_y;
    sel_rx   = skid_v_r ? skid_rx_r   : in_right_x;
  end

  always_comb begin
    s1_nxt.keep  = (sel_dist < threshold) && (sel_lx > sel_rx);
    s1_nxt.num   = smt_pkg::NUM_W'(baseline) * smt_pkg::NUM_W'(focal_x);
    s1_nxt.disp  = sel_lx - sel_rx;
    s1_nxt.off_x = $signed({1'b0, sel_lx}) - $signed({1'b0, center_x});
    s1_nxt.off_y = $signed({1'b0, sel_ly}) - $signed({1'b0, center_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (en) begin
      skid_v_r <= 1'b0;
    end else if (in_acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_acc) begin
      skid_dist_r <= in_match_distance;
      skid_lidx_r <= in_left_index;
      skid_ridx_r <= in_right_index;
      skid_lx_r   <= in_left_x;
      skid_ly_r   <= in_left_y;
      skid_rx_r   <= in_right_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= sel_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r      <= s1_nxt;
      s1_dist_r <= sel_dist;
      s1_lidx_r <= sel_lidx;
      s1_ridx_r <= sel_ridx;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign s1_dist  = s1_dist_r;
  assign s1_lidx  = s1_lidx_r;
  assign s1_ridx  = s1_ridx_r;

endmodule

FILE: rtl/smt_div.sv
module smt_div #(
  parameter int DW = 36,
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [DW-1:0]               dividend,
  input  logic [smt_pkg::FOC_W-1:0]   divisor,
  input  logic [SW-1:0]               side_i,
  output logic                        out_v,
  output logic [smt_pkg::QUO_W-1:0]   quo,
  output logic                        ovf,
  output logic [SW-1:0]               side_o
);

  localparam int QW = smt_pkg::QUO_W;
  localparam int RW = smt_pkg::FOC_W;
  localparam int TW = DW - QW;
  localparam int CW = (TW > RW) ? TW : RW;

  logic          v_r    [0:QW];
  logic          ovf_r  [0:QW];
  logic [RW-1:0] rem_r  [0:QW];
  logic [QW-1:0] lo_r   [0:QW];
  logic [RW-1:0] dvs_r  [0:QW];
  logic [SW-1:0] side_r [0:QW];

  // entry: quotient of 2^QW or more flags overflow; otherwise top bits are the start remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0]  <= CW'(dividend[DW-1:QW]) >= CW'(divisor);
      rem_r[0]  <= RW'(dividend[DW-1:QW]);
      lo_r[0]   <= dividend[QW-1:0];
      dvs_r[0]  <= divisor;
      side_r[0] <= side_i;
    end
  end

  // one restoring step per stage; quotient bits shift into lo as dividend bits leave
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        ge;

    assign trial = {rem_r[k-1], lo_r[k-1][QW-1]};
    assign diff  = trial - {1'b0, dvs_r[k-1]};
    assign ge    = trial >= {1'b0, dvs_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
        lo_r[k]   <= {lo_r[k-1][QW-2:0], ge};
        ovf_r[k]  <= ovf_r[k-1];
        dvs_r[k]  <= dvs_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_v  = v_r[QW];
  assign quo    = lo_r[QW];
  assign ovf    = ovf_r[QW];
  assign side_o = side_r[QW];

endmodule

FILE: rtl/smt_proj.sv
module smt_proj #(
  parameter int PW = 33
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic                              keep,
  input  logic signed [smt_pkg::OFF_W-1:0]  off_x,
  input  logic signed [smt_pkg::OFF_W-1:0]  off_y,
  input  logic [smt_pkg::QUO_W-1:0]         z,
  input  logic                              z_ovf,
  input  logic [PW-1:0]                     pass_i,
  input  logic [smt_pkg::DEPTH_W-1:0]       max_depth,
  output logic                              p_valid,
  output logic                              p_ok,
  output logic [smt_pkg::DEPTH_W-1:0]       p_z,
  output logic [smt_pkg::PROD_W-1:0]        mag_x,
  output logic                              neg_x,
  output logic [smt_pkg::PROD_W-1:0]        mag_y,
  output logic                              neg_y,
  output logic [PW-1:0]                     pass_o
);

  logic [smt_pkg::OFF_W-1:0]   abs_x;
  logic [smt_pkg::OFF_W-1:0]   abs_y;
  logic                        ok_nxt;

  logic                        p_valid_r;
  logic                        p_ok_r;
  logic [smt_pkg::DEPTH_W-1:0] p_z_r;
  logic [smt_pkg::PROD_W-1:0]  mag_x_r;
  logic                        neg_x_r;
  logic [smt_pkg::PROD_W-1:0]  mag_y_r;
  logic                        neg_y_r;
  logic [PW-1:0]               pass_r;

  assign abs_x  = off_x[smt_pkg::OFF_W-1] ? smt_pkg::OFF_W'(-off_x) : off_x;
  assign abs_y  = off_y[smt_pkg::OFF_W-1] ? smt_pkg::OFF_W'(-off_y) : off_y;
  // front checks must pass; depth must be positive, not overflowed and below the limit
  assign ok_nxt = keep && !z_ovf && (z != '0) && (z < max_depth);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ok_r  <= ok_nxt;
      p_z_r   <= z;
      mag_x_r <= abs_x[smt_pkg::PIX_W-1:0] * z;
      mag_y_r <= abs_y[smt_pkg::PIX_W-1:0] * z;
      neg_x_r <= off_x[smt_pkg::OFF_W-1];
      neg_y_r <= off_y[smt_pkg::OFF_W-1];
      pass_r  <= pass_i;
    end
  end

  assign p_valid = p_valid_r;
  assign p_ok    = p_ok_r;
  assign p_z     = p_z_r;
  assign mag_x   = mag_x_r;
  assign neg_x   = neg_x_r;
  assign mag_y   = mag_y_r;
  assign neg_y   = neg_y_r;
  assign pass_o  = pass_r;

endmodule

FILE: rtl/smt_out.sv
module smt_out #(
  parameter int INDEX_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         en,
  input  logic                         x_v,
  input  logic                         y_v,
  input  logic                         ok,
  input  logic [smt_pkg::QUO_W-1:0]    qx,
  input  logic                         ovf_x,
  input  logic                         neg_x,
  input  logic [smt_pkg::QUO_W-1:0]    qy,
  input  logic                         ovf_y,
  input  logic                         neg_y,
  input  logic [smt_pkg::DEPTH_W-1:0]  z,
  input  logic [smt_pkg::DIST_W-1:0]   match_dist,
  input  logic [INDEX_BITS-1:0]        lidx,
  input  logic [INDEX_BITS-1:0]        ridx,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [smt_pkg::DEPTH_W-1:0]  out_point_x,
  output logic [smt_pkg::DEPTH_W-1:0]  out_point_y,
  output logic [smt_pkg::DEPTH_W-1:0]  out_point_z,
  output logic [INDEX_BITS-1:0]        out_kept_left_index,
  output logic [INDEX_BITS-1:0]        out_kept_right_index,
  output logic [smt_pkg::DIST_W-1:0]   out_score
);

  logic                        out_valid_r;
  logic [smt_pkg::DEPTH_W-1:0] px_r;
  logic [smt_pkg::DEPTH_W-1:0] py_r;
  logic [smt_pkg::DEPTH_W-1:0] pz_r;
  logic [INDEX_BITS-1:0]       lidx_r;
  logic [INDEX_BITS-1:0]       ridx_r;
  logic [smt_pkg::DIST_W-1:0]  score_r;

  // apply sign to truncated magnitude quotient and clamp to Q8.16
  function automatic logic [smt_pkg::DEPTH_W-1:0] sat_q(
    input logic [smt_pkg::QUO_W-1:0] q,
    input logic                      over,
    input logic                      neg
  );
    logic [smt_pkg::DEPTH_W-1:0] r;
    if (over) begin
      r = neg ? smt_pkg::NEG_SAT : smt_pkg::POS_SAT;
    end else if (!neg) begin
      r = (q >= smt_pkg::SAT_LIM) ? smt_pkg::POS_SAT : q;
    end else begin
      r = (q > smt_pkg::SAT_LIM) ? smt_pkg::NEG_SAT : smt_pkg::DEPTH_W'(-q);
    end
    return r;
  endfunction

  assign en = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= x_v && y_v && ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= sat_q(qx, ovf_x, neg_x);
      py_r    <= sat_q(qy, ovf_y, neg_y);
      pz_r    <= z;
      lidx_r  <= lidx;
      ridx_r  <= ridx;
      score_r <= match_dist;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_point_x          = px_r;
  assign out_point_y          = py_r;
  assign out_point_z          = pz_r;
  assign out_kept_left_index  = lidx_r;
  assign out_kept_right_index = ridx_r;
  assign out_score            = score_r;

endmodule

FILE: rtl/smt_chk.sv
module smt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [smt_pkg::DEPTH_W-1:0]      out_point_z
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // no point leaves with zero depth
  a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_z != '0)
    else $error("result with zero depth");

  // the input only stalls after the result side held a result back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without result-side stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_point_z))
    else $error("stalled result changed");

endmodule

bind stereo_match_triangulator_unit smt_chk u_smt_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_point_z (out_point_z)
);

FILE: verif/stereo_match_triangulator_unit_test.sv
`timescale 1ns / 100ps

module stereo_match_triangulator_unit_test;

  localparam int IDX_W        = 12;
  localparam int DRAIN_CYCLES = 80;      // comfortably past the pipeline latency
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [smt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // beyond the register file
  localparam longint Q816_HI  = 8388607;
  localparam longint Q816_LO  = -8388608;

  typedef struct packed {
    logic [smt_pkg::DIST_W-1:0] distance;
    logic [IDX_W-1:0]           left_idx;
    logic [IDX_W-1:0]           right_idx;
    logic [smt_pkg::PIX_W-1:0]  lx;
    logic [smt_pkg::PIX_W-1:0]  ly;
    logic [smt_pkg::PIX_W-1:0]  rx;
  } match_t;

  typedef struct packed {
    logic [smt_pkg::DEPTH_W-1:0] px;
    logic [smt_pkg::DEPTH_W-1:0] py;
    logic [smt_pkg::DEPTH_W-1:0] pz;
    logic [IDX_W-1:0]            left_idx;
    logic [IDX_W-1:0]            right_idx;
    logic [smt_pkg::DIST_W-1:0]  score;
  } point_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports, inputs all known from time zero
  logic                          cfg_we    = 1'b0;
  logic [smt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [smt_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [smt_pkg::DIST_W-1:0]    in_match_distance = '0;
  logic [IDX_W-1:0]              in_left_index     = '0;
  logic [IDX_W-1:0]              in_right_index    = '0;
  logic [smt_pkg::PIX_W-1:0]     in_left_x         = '0;
  logic [smt_pkg::PIX_W-1:0]     in_left_y         = '0;
  logic [smt_pkg::PIX_W-1:0]     in_right_x        = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [smt_pkg::DEPTH_W-1:0]   out_point_x;
  logic [smt_pkg::DEPTH_W-1:0]   out_point_y;
  logic [smt_pkg::DEPTH_W-1:0]   out_point_z;
  logic [IDX_W-1:0]              out_kept_left_index;
  logic [IDX_W-1:0]              out_kept_right_index;
  logic [smt_pkg::DIST_W-1:0]    out_score;

  stereo_match_triangulator_unit #(
    .INDEX_BITS(IDX_W)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_match_distance    (in_match_distance),
    .in_left_index        (in_left_index),
    .in_right_index       (in_right_index),
    .in_left_x            (in_left_x),
    .in_left_y            (in_left_y),
    .in_right_x           (in_right_x),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_point_x          (out_point_x),
    .out_point_y          (out_point_y),
    .out_point_z          (out_point_z),
    .out_kept_left_index  (out_kept_left_index),
    .out_kept_right_index (out_kept_right_index),
    .out_score            (out_score)
  );

  // camera setup as the block should hold it; starts at the reset values
  logic [smt_pkg::FOC_W-1:0]   fx          = smt_pkg::RST_FOCAL_X;
  logic [smt_pkg::FOC_W-1:0]   fy          = smt_pkg::RST_FOCAL_Y;
  logic [smt_pkg::PIX_W-1:0]   cx          = smt_pkg::RST_CENTER_X;
  logic [smt_pkg::PIX_W-1:0]   cy          = smt_pkg::RST_CENTER_Y;
  logic [smt_pkg::BASE_W-1:0]  base_len    = smt_pkg::RST_BASELINE;
  logic [smt_pkg::DIST_W-1:0]  dist_limit  = smt_pkg::RST_THRESHOLD;
  logic [smt_pkg::DEPTH_W-1:0] depth_limit = smt_pkg::RST_MAX_DEPTH;

  match_t match_queue[$];      // matches waiting for the driver
  point_t pending_points[$];   // points predicted but not yet seen

  int     matches_queued = 0;
  int     matches_taken  = 0;
  int     mismatches     = 0;
  int     cycles         = 0;
  int     send_gap_pct   = 0;
  int     recv_stall_pct = 0;
  bit     draining       = 1'b0;
  bit     in_taken       = 1'b0;
  match_t seen_match;
  point_t seen_point;
  point_t predicted;

  // ---------------------------------------------------------------------------
  // Triangulation model
  // ---------------------------------------------------------------------------
  function automatic logic [smt_pkg::DEPTH_W-1:0] clamp_q816(input longint v);
    if (v > Q816_HI) v = Q816_HI;
    if (v < Q816_LO) v = Q816_LO;
    return v[smt_pkg::DEPTH_W-1:0];
  endfunction

  // offset from the principal point scaled by depth over focal length;
  // signed division truncates toward zero, a zero focal length counts as one
  function automatic logic [smt_pkg::DEPTH_W-1:0] project_axis(
    input logic [smt_pkg::PIX_W-1:0] pix,
    input logic [smt_pkg::PIX_W-1:0] centre,
    input longint unsigned           z,
    input logic [smt_pkg::FOC_W-1:0] focal
  );
    longint off;
    longint f;
    off = longint'(pix) - longint'(centre);
    f   = (focal == 0) ? 1 : longint'(focal);
    return clamp_q816((off * longint'(z)) / f);
  endfunction

  // returns 1 when the match yields a point
  function automatic bit triangulate(input match_t m, output point_t p);
    longint unsigned num;
    longint unsigned disp;
    longint unsigned z;
    p = '0;
    if (m.distance >= dist_limit) return 0;
    if (m.lx <= m.rx) return 0;          // zero or negative disparity
    disp = longint'(m.lx - m.rx);
    num  = longint'(base_len) * longint'(fx);
    z    = num / disp;
    if (z == 0 || z >= depth_limit) return 0;
    p.px        = project_axis(m.lx, cx, z, fx);
    p.py        = project_axis(m.ly, cy, z, fy);
    p.pz        = z[smt_pkg::DEPTH_W-1:0];
    p.left_idx  = m.left_idx;
    p.right_idx = m.right_idx;
    p.score     = m.distance;
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: acceptance and prediction at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        matches_taken = matches_taken + 1;
        seen_match = {in_match_distance, in_left_index, in_right_index,
                      in_left_x, in_left_y, in_right_x};
        if (triangulate(seen_match, predicted))
          pending_points.insert(pending_points.size(), predicted);
      end
    end
  end

  // Driver: moves on once the current transfer is taken, or when idle.
  // in_valid is only updated at falling edges.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (match_queue.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          {in_match_distance, in_left_index, in_right_index,
           in_left_x, in_left_y, in_right_x} <= match_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall generation and checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what,
                                 input logic [smt_pkg::DEPTH_W-1:0] got,
                                 input logic [smt_pkg::DEPTH_W-1:0] want);
    mismatches = mismatches + 1;
    $display("cycle %0d: %s got %h, expected %h", cycles, what, got, want);
  endtask

  task automatic check_point(input point_t got);
    point_t want;
    if (pending_points.size() == 0) begin
      report_mismatch("unexpected point, depth", got.pz, '0);
      return;
    end
    want = pending_points.pop_front();
    if (got.px !== want.px) report_mismatch("point_x", got.px, want.px);
    if (got.py !== want.py) report_mismatch("point_y", got.py, want.py);
    if (got.pz !== want.pz) report_mismatch("point_z", got.pz, want.pz);
    if (got.left_idx !== want.left_idx)
      report_mismatch("kept_left_index", smt_pkg::DEPTH_W'(got.left_idx),
                      smt_pkg::DEPTH_W'(want.left_idx));
    if (got.right_idx !== want.right_idx)
      report_mismatch("kept_right_index", smt_pkg::DEPTH_W'(got.right_idx),
                      smt_pkg::DEPTH_W'(want.right_idx));
    if (got.score !== want.score)
      report_mismatch("score", smt_pkg::DEPTH_W'(got.score), smt_pkg::DEPTH_W'(want.score));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_point = {out_point_x, out_point_y, out_point_z,
                    out_kept_left_index, out_kept_right_index, out_score};
      check_point(seen_point);
    end
  end

  // receiver back-pressure; forced off while the pipe is being flushed
  always @(negedge clk) begin
    if (rst_n) out_stall <= !draining && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_match(input match_t m);
    match_queue.insert(match_queue.size(), m);
    matches_queued = matches_queued + 1;
  endtask

  task automatic push_match(input int distance, input int li, input int ri,
                            input int lx, input int ly, input int rx);
    match_t m;
    m.distance  = smt_pkg::DIST_W'(distance);
    m.left_idx  = IDX_W'(li);
    m.right_idx = IDX_W'(ri);
    m.lx        = smt_pkg::PIX_W'(lx);
    m.ly        = smt_pkg::PIX_W'(ly);
    m.rx        = smt_pkg::PIX_W'(rx);
    add_match(m);
  endtask

  // Mostly well-formed matches aimed inside the current depth window, some
  // sitting right on the threshold or the depth limit, the rest pure noise.
  task automatic push_random();
    match_t          m;
    longint unsigned num;
    longint unsigned dmin;
    longint unsigned dmax;
    longint unsigned d;
    int              pick;
    pick        = $urandom_range(0, 99);
    m.distance  = smt_pkg::DIST_W'($urandom_range(0, 256));
    m.left_idx  = IDX_W'($urandom);
    m.right_idx = IDX_W'($urandom);
    m.lx        = smt_pkg::PIX_W'($urandom);
    m.ly        = smt_pkg::PIX_W'($urandom);
    m.rx        = smt_pkg::PIX_W'($urandom);
    num  = longint'(base_len) * longint'(fx);
    dmin = num / depth_limit + 1;
    dmax = (num < 65535) ? num : 65535;
    if (pick < 88 && dmin <= dmax) begin
      if (dist_limit != 0)
        m.distance = smt_pkg::DIST_W'($urandom_range(0, dist_limit - 1));
      d = ($urandom_range(0, 3) == 0) ? dmin : dmin + ($urandom % (dmax - dmin + 1));
      if (pick >= 76) begin
        if (pick[0]) m.distance = dist_limit;   // exactly at threshold
        else if (dmin > 1) d = dmin - 1;        // depth lands on the limit
      end
      m.lx = smt_pkg::PIX_W'($urandom_range(65535, 32'(d)));
      m.rx = m.lx - smt_pkg::PIX_W'(d);
    end
    add_match(m);
  endtask

  task automatic push_randoms(input int n);
    repeat (n) push_random();
  endtask

  task automatic hold_until_sent();
    while (matches_taken != matches_queued) @(negedge clk);
  endtask

  task automatic hold_until_points_in();
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  // everything sent, every point back, then flush matches that give nothing
  task automatic settle();
    hold_until_sent();
    hold_until_points_in();
    draining = 1'b1;
    repeat (DRAIN_CYCLES) @(negedge clk);
    draining = 1'b0;
  endtask

  // called at a falling edge; drops cfg_we again before it returns
  task automatic write_reg(input logic [smt_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= smt_pkg::CFG_W'(val);
    case (idx)
      smt_pkg::REG_FOCAL_X:   fx          = val[smt_pkg::FOC_W-1:0];
      smt_pkg::REG_FOCAL_Y:   fy          = val[smt_pkg::FOC_W-1:0];
      smt_pkg::REG_CENTER_X:  cx          = val[smt_pkg::PIX_W-1:0];
      smt_pkg::REG_CENTER_Y:  cy          = val[smt_pkg::PIX_W-1:0];
      smt_pkg::REG_BASELINE:  base_len    = val[smt_pkg::BASE_W-1:0];
      smt_pkg::REG_THRESHOLD: dist_limit  = val[smt_pkg::DIST_W-1:0];
      smt_pkg::REG_MAX_DEPTH: depth_limit = val[smt_pkg::DEPTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_camera(input int fxv, input int fyv, input int cxv, input int cyv,
                              input int basev, input int thrv, input int maxv);
    write_reg(smt_pkg::REG_FOCAL_X, fxv);
    write_reg(smt_pkg::REG_FOCAL_Y, fyv);
    write_reg(smt_pkg::REG_CENTER_X, cxv);
    write_reg(smt_pkg::REG_CENTER_Y, cyv);
    write_reg(smt_pkg::REG_BASELINE, basev);
    write_reg(smt_pkg::REG_THRESHOLD, thrv);
    write_reg(smt_pkg::REG_MAX_DEPTH, maxv);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- sender gappy, receiver stalling hard ----
    set_idling(34, 63);

    // reset setup: depth limit sits between disparity 114 and 115
    push_match(0, 0, 4095, 6000, 4000, 5000);        // plain keeper
    push_match(49, 4095, 0, 5120, 3840, 4000);       // one below threshold, on centre
    push_match(50, 1, 2, 6000, 4000, 5000);          // at threshold
    push_match(256, 3, 4, 6000, 4000, 5000);         // largest distance the bench drives
    push_match(0, 5, 6, 5000, 4000, 5000);           // zero disparity
    push_match(0, 7, 8, 4000, 4000, 5000);           // negative disparity
    push_match(10, 9, 10, 65535, 0, 65421);          // depth on the limit
    push_match(10, 11, 12, 65535, 0, 65420);         // just inside, x saturates high
    push_match(10, 13, 14, 115, 65535, 0);           // negative x offset
    push_match(1, 2730, 1365, 65535, 65535, 0);      // widest disparity
    push_match(1, 15, 16, 65535, 65535, 65534);      // unit disparity, far too deep
    push_match(0, 0, 0, 0, 0, 0);
    push_match(0, 4095, 4095, 65535, 65535, 65535);
    // sender holds off until every point is back before carrying on
    hold_until_sent();
    hold_until_points_in();
    push_randoms(110);
    settle();

    // near-largest values; centre in the far corner drives x and y negative
    setup_camera(65535, 65535, 65535, 65535, 1048575, 256, 16777215);
    push_match(0, 100, 200, 8000, 0, 3903);          // both axes saturate low
    push_randoms(150);
    settle();

    // smallest optics: only unit disparity gives a non-zero depth
    setup_camera(1, 1, 0, 0, 1, 256, 16777215);
    push_match(0, 1, 1, 2, 5, 0);                    // depth truncates to zero
    push_match(255, 4095, 4095, 65535, 65535, 65534);
    push_randoms(80);
    settle();

    // nothing can pass; the out-of-range index must not disturb anything
    write_reg(smt_pkg::REG_THRESHOLD, 0);
    write_reg(smt_pkg::REG_MAX_DEPTH, 1);
    write_reg(REG_UNUSED, 'hFFFFFF);
    push_randoms(30);
    settle();

    // ---- roles swapped ----
    set_idling(63, 34);

    // zero horizontal focal length: depth is always zero
    setup_camera(0, 8000, 5120, 3840, 32768, 256, 2293760);
    push_randoms(20);
    settle();

    // zero baseline: same outcome
    write_reg(smt_pkg::REG_FOCAL_X, 8000);
    write_reg(smt_pkg::REG_BASELINE, 0);
    push_randoms(20);
    settle();

    // zero vertical focal length: divisor taken as one, y mostly saturates
    write_reg(smt_pkg::REG_BASELINE, 32768);
    write_reg(smt_pkg::REG_FOCAL_Y, 0);
    push_randoms(60);
    settle();

    repeat (4) begin
      if (send_gap_pct != 0 && recv_stall_pct == 34 && matches_queued > 700)
        set_idling(0, 0);   // last stretch runs flat out
      setup_camera($urandom_range(1, 65535), $urandom_range(1, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1, 1048575), $urandom_range(0, 256),
                   $urandom_range(1, 16777215));
      push_randoms(110);
      settle();
      if (recv_stall_pct == 34) set_idling(0, 0);
    end

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/smt_pkg.sv
rtl/smt_front.sv
rtl/smt_div.sv
rtl/smt_proj.sv
rtl/smt_out.sv
rtl/stereo_match_triangulator_unit.sv
rtl/smt_chk.sv
verif/stereo_match_triangulator_unit_test.sv
